>>> sv/bil_pkg.sv
// constants and request/status codes for the bounded indexed list
package bil_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_INSERT  = 3'd1;
  localparam logic [2:0] KIND_PREPEND = 3'd2;
  localparam logic [2:0] KIND_POP     = 3'd3;
  localparam logic [2:0] KIND_DELETE  = 3'd4;
  localparam logic [2:0] KIND_REMOVE  = 3'd5;
  localparam logic [2:0] KIND_FIND    = 3'd6;
  localparam logic [2:0] KIND_READ    = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

endpackage

>>> sv/bounded_indexed_list.sv
// bounded indexed list: packed list of words with a one-word-per-cycle walker
//
// input channel (in_valid/in_stall) takes one request word: kind, index, value.
// output channel (out_valid/out_stall) returns one result word per request.
// the list lives in a 16-entry ram with one write and one registered read port;
// a small sequencer walks it one stored word per cycle.
// words walked per request (n = length before the request):
//   append, insert at the end and refused requests: no walk, straight to done
//   insert/prepend inside the list and delete: n-index words, pop/read: one word
//   remove all and find: n words (no walk on an empty list)
// the ram read port sets the walk: one stored word is read per cycle, then
// the last read data arrives, the walk closes and the result is loaded.
// in_stall is high from accept until the result is loaded into the output
// register, so at most one request is in flight; the next one can be taken the
// cycle after the result is loaded.
// if the receiver stalls, the result word holds and a finished request waits
// in the done state until the output register frees.
// reset empties the list (length zero) and drops any pending result; the ram
// contents are left as they are since only positions below the length are read.
module bounded_indexed_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  kind,
  input  logic [3:0]                  index,
  input  logic [31:0]                 value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 data_out,
  output logic [3:0]                  position,
  output logic                        found,
  output logic [4:0]                  removed_count,
  output logic [4:0]                  length_now,
  output logic                        empty_res,
  output logic [1:0]                  status
);

  import bil_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      count;
  logic [2:0]            op;
  logic [ADDR_W-1:0]     idx;
  logic [DATA_WIDTH-1:0] val;
  logic [1:0]            st;
  logic [DATA_WIDTH-1:0] dat;
  logic [ADDR_W-1:0]     pos;
  logic                  fnd;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W-1:0]      wpos;
  logic [ADDR_W-1:0]     ptr;
  logic [CNT_W-1:0]      left;
  logic                  down;
  logic                  pv;
  logic [ADDR_W-1:0]     pi;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  accept;
  logic [ADDR_W-1:0]     idx_in;
  logic [CNT_W-1:0]      idx_in_w;
  logic                  full;
  logic                  list_empty;
  logic                  ins_kind;
  logic                  ins_ok;
  logic                  walk_end;
  logic                  match;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign ins_kind   = (kind == KIND_INSERT) || (kind == KIND_PREPEND);
  assign idx_in     = (kind == KIND_PREPEND) ? '0 : index[ADDR_W-1:0];
  assign idx_in_w   = CNT_W'(idx_in);
  assign full       = (count >= CNT_W'(CAPACITY));
  assign list_empty = (count == '0);
  assign ins_ok     = !full && (idx_in_w <= count);
  assign walk_end   = (state == S_WALK) && (left == '0) && !pv;
  assign match      = (rdata == val);

  // single write port: append/direct insert, walk moves, final insert
  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = rdata;
    if (accept && kind == KIND_APPEND && !full) begin
      we    = 1'b1;
      wdata = value[DATA_WIDTH-1:0];
    end else if (accept && ins_kind && ins_ok && idx_in_w == count) begin
      we    = 1'b1;
      waddr = idx_in;
      wdata = value[DATA_WIDTH-1:0];
    end else if (state == S_WALK && pv) begin
      case (op)
        KIND_INSERT, KIND_PREPEND: begin
          we    = 1'b1;
          waddr = pi + 1'b1;
        end
        KIND_DELETE: begin
          we    = (pi != idx);
          waddr = pi - 1'b1;
        end
        KIND_REMOVE: begin
          we    = !match;
          waddr = wpos[ADDR_W-1:0];
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (walk_end && (op == KIND_INSERT || op == KIND_PREPEND)) begin
      we    = 1'b1;
      waddr = idx;
      wdata = val;
    end
  end

  bil_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
      left      <= '0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= kind;
            idx  <= idx_in;
            val  <= value[DATA_WIDTH-1:0];
            st   <= ST_OK;
            dat  <= '0;
            pos  <= '0;
            fnd  <= 1'b0;
            rem  <= '0;
            wpos <= '0;
            pv   <= 1'b0;
            left <= '0;
            down <= 1'b0;
            ptr  <= '0;
            state <= S_DONE;
            case (kind)
              KIND_APPEND: begin
                if (full) begin
                  st <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              KIND_INSERT, KIND_PREPEND: begin
                if (full) begin
                  st <= ST_FULL;
                end else if (idx_in_w > count) begin
                  st <= ST_RANGE;
                end else if (idx_in_w == count) begin
                  count <= count + 1'b1;
                end else begin
                  // move the tail up, highest word first
                  ptr   <= ADDR_W'(count - 1'b1);
                  left  <= count - idx_in_w;
                  down  <= 1'b1;
                  state <= S_WALK;
                end
              end
              KIND_POP: begin
                if (list_empty) begin
                  st <= ST_EMPTY;
                end else begin
                  ptr   <= ADDR_W'(count - 1'b1);
                  left  <= CNT_W'(1);
                  state <= S_WALK;
                end
              end
              KIND_DELETE: begin
                if (list_empty) begin
                  st <= ST_EMPTY;
                end else if (idx_in_w >= count) begin
                  st <= ST_RANGE;
                end else begin
                  ptr   <= idx_in;
                  left  <= count - idx_in_w;
                  state <= S_WALK;
                end
              end
              KIND_REMOVE, KIND_FIND: begin
                if (!list_empty) begin
                  left  <= count;
                  state <= S_WALK;
                end
              end
              default: begin
                if (idx_in_w >= count) begin
                  st <= ST_RANGE;
                end else begin
                  ptr   <= idx_in;
                  left  <= CNT_W'(1);
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          // issue the next read
          if (left != '0) begin
            pv   <= 1'b1;
            pi   <= ptr;
            ptr  <= down ? ptr - 1'b1 : ptr + 1'b1;
            left <= left - 1'b1;
          end else begin
            pv <= 1'b0;
          end
          // handle the word read last cycle
          if (pv) begin
            case (op)
              KIND_POP, KIND_READ: begin
                dat <= rdata;
              end
              KIND_DELETE: begin
                if (pi == idx) begin
                  dat <= rdata;
                end
              end
              KIND_REMOVE: begin
                if (match) begin
                  rem <= rem + 1'b1;
                end else begin
                  wpos <= wpos + 1'b1;
                end
              end
              KIND_FIND: begin
                if (match && !fnd) begin
                  fnd <= 1'b1;
                  pos <= pi;
                end
              end
              default: begin
              end
            endcase
          end
          if (walk_end) begin
            state <= S_DONE;
            case (op)
              KIND_INSERT, KIND_PREPEND: count <= count + 1'b1;
              KIND_POP, KIND_DELETE:     count <= count - 1'b1;
              KIND_REMOVE:               count <= wpos;
              default: begin
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            data_out      <= 32'(dat);
            position      <= 4'(pos);
            found         <= fnd;
            removed_count <= 5'(rem);
            length_now    <= 5'(count);
            empty_res     <= (count == '0);
            status        <= st;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/bil_ram.sv
// generic single-write, single-read ram with registered read data
module bil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
